FILE: rtl/ott_pkg.sv
// Shared types and constants of the odd-even transposition sorter.
`default_nettype none

package ott_pkg;

    localparam int VALUE_W      = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [VALUE_W-1:0] value_t;

    // One queued request: the byte and whether it completes a set.
    typedef struct packed {
        value_t value;
        logic   set_end;
    } q_entry_t;

    // Push side of the queue as driven by the front end.
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/ott_front.sv
// Front end: accepts input requests and tags the one that completes a set.
`default_nettype none

module ott_front #(
    parameter int NUM_ITEMS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire ott_pkg::value_t value_in,
    input  wire logic            q_full,
    output ott_pkg::q_push_t     push
);

    localparam int CNT_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(NUM_ITEMS - 1);

    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] pos_next;
    logic             accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        push.valid         = accept;
        push.entry.value   = value_in;
        push.entry.set_end = (pos_reg == LAST_POS);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            // wrap to the first position once a set is complete
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ott_queue.sv
// Short request queue between the front end and the sorting back end.
`default_nettype none

module ott_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ott_pkg::q_push_t  push,
    output logic                   full,
    output logic                   q_valid,
    output ott_pkg::q_entry_t      q_entry,
    input  wire logic              q_pop
);

    localparam int DEPTH = ott_pkg::QUEUE_DEPTH;
    localparam int PTR_W = ott_pkg::QUEUE_PTR_W;
    localparam int CNT_W = ott_pkg::QUEUE_CNT_W;

    ott_pkg::q_entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ott_back.sv
// Back end: element row, compare-exchange phases and sorted output.
`default_nettype none

module ott_back #(
    parameter int NUM_ITEMS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire ott_pkg::q_entry_t q_entry,
    output logic                   q_pop,
    output ott_pkg::value_t        value_out,
    output logic                   last_out,
    output logic                   out_valid,
    input  wire logic              out_stall
);

    localparam int CNT_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_ITEMS - 1);

    ott_pkg::back_state_t state_reg;
    ott_pkg::back_state_t state_next;
    ott_pkg::value_t      store_reg  [NUM_ITEMS];
    ott_pkg::value_t      store_next [NUM_ITEMS];
    logic [CNT_W-1:0]     phase_reg;
    logic [CNT_W-1:0]     phase_next;
    logic [CNT_W-1:0]     emit_reg;
    logic [CNT_W-1:0]     emit_next;
    logic                 out_take;

    assign out_take  = out_valid && !out_stall;
    assign value_out = store_reg[0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ott_pkg::ST_LOAD:
            begin
                if (q_valid && q_entry.set_end)
                begin
                    state_next = ott_pkg::ST_SORT;
                end
            end
            ott_pkg::ST_SORT:
            begin
                if (phase_reg == LAST_IDX)
                begin
                    state_next = ott_pkg::ST_EMIT;
                end
            end
            ott_pkg::ST_EMIT:
            begin
                if (out_take && (emit_reg == LAST_IDX))
                begin
                    state_next = ott_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = ott_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
        last_out  = 1'b0;
        case (state_reg)
            ott_pkg::ST_LOAD:
            begin
                q_pop = q_valid;
            end
            ott_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                last_out  = (emit_reg == LAST_IDX);
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // counters
    always_comb
    begin
        phase_next = phase_reg;
        emit_next  = emit_reg;
        case (state_reg)
            ott_pkg::ST_LOAD:
            begin
                phase_next = '0;
                emit_next  = '0;
            end
            ott_pkg::ST_SORT:
            begin
                phase_next = phase_reg + CNT_W'(1);
            end
            ott_pkg::ST_EMIT:
            begin
                if (out_take)
                begin
                    emit_next = emit_reg + CNT_W'(1);
                end
            end
            default:
            begin
                phase_next = '0;
            end
        endcase
    end

    // element row: shift in on load, one phase per sort cycle, shift out on emit
    always_comb
    begin
        for (int i = 0; i < NUM_ITEMS; i++)
        begin
            store_next[i] = store_reg[i];
        end
        case (state_reg)
            ott_pkg::ST_LOAD:
            begin
                if (q_valid)
                begin
                    for (int i = 0; i < NUM_ITEMS - 1; i++)
                    begin
                        store_next[i] = store_reg[i + 1];
                    end
                    store_next[NUM_ITEMS - 1] = q_entry.value;
                end
            end
            ott_pkg::ST_SORT:
            begin
                for (int i = 0; i < NUM_ITEMS - 1; i++)
                begin
                    if (((i & 1) == int'(phase_reg[0])) && (store_reg[i] > store_reg[i + 1]))
                    begin
                        store_next[i]     = store_reg[i + 1];
                        store_next[i + 1] = store_reg[i];
                    end
                end
            end
            ott_pkg::ST_EMIT:
            begin
                if (out_take)
                begin
                    for (int i = 0; i < NUM_ITEMS - 1; i++)
                    begin
                        store_next[i] = store_reg[i + 1];
                    end
                end
            end
            default:
            begin
                store_next[0] = store_reg[0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ott_pkg::ST_LOAD;
            phase_reg <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_ITEMS; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

    a_set_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ott_pkg::ST_LOAD && q_valid && q_entry.set_end)
        |=> (state_reg == ott_pkg::ST_SORT && phase_reg == '0))
        else $error("completed set did not start the sort at phase zero");

    a_sort_ends_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ott_pkg::ST_SORT && phase_reg == LAST_IDX)
        |=> (state_reg == ott_pkg::ST_EMIT && emit_reg == '0))
        else $error("sort did not hand over to output at the first value");

    a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last_out) |=> (state_reg == ott_pkg::ST_LOAD && !out_valid))
        else $error("output continued after the last value");

endmodule

`default_nettype wire

FILE: rtl/odd_even_transposition_sorter.sv
// Top level of the odd-even transposition sorter.
`default_nettype none

// Collects NUM_ITEMS unsigned bytes, one per input request, sorts them with
// NUM_ITEMS odd-even compare-exchange phases and returns them smallest first,
// with last_out high on the final value of each set. The front end counts
// load positions and tags the request that completes a set; a two-entry
// queue parts it from the back end, so input requests keep flowing while the
// back end is busy until the queue fills. The back end holds the elements in
// a row of registers: it shifts in one value per cycle while the queue holds
// one, then runs one phase per cycle (all pairs of that phase compared in
// parallel), then shifts one result per accepted output request out of
// position zero. Up to two values of the next set are taken into the queue
// while a set is being sorted or emitted.
module odd_even_transposition_sorter #(
    parameter int NUM_ITEMS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           value_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                value_out,
    output logic                      last_out
);

    ott_pkg::q_push_t  push;
    ott_pkg::q_entry_t q_entry;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    // accept requests and mark the one that fills the last position
    ott_front #(
        .NUM_ITEMS (NUM_ITEMS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value_in (value_in),
        .q_full   (q_full),
        .push     (push)
    );

    // hold requests while the back end sorts or emits
    ott_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    // load, sort and drain the element row
    ott_back #(
        .NUM_ITEMS (NUM_ITEMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .value_out (value_out),
        .last_out  (last_out),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire
